### rtl/core/mrtu_pkg.sv
// Shared types and constants for the Modbus RTU master transaction unit.
// Used by the CRC unit and the top level; no dependencies.
package mrtu_pkg;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  FUNC_WRITE    = 8'h06;
   localparam logic [7:0]  FUNC_READ     = 8'h03;
   localparam logic [7:0]  DEVICE_RESET  = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [0:0] {
      REG_DEVICE_ADDRESS = 1'b0,
      REG_TIMEOUT_TICKS  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_BYTE  = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_READ   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_CRC_BAD     = 3'd1,
      ST_NO_REPLY    = 3'd2,
      ST_SHORT_REPLY = 3'd3,
      ST_WRONG_DEV   = 3'd4,
      ST_ECHO_BAD    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REQ_CRC,
      S_REQ_WAIT,
      S_TX,
      S_RX_CRC,
      S_EVAL,
      S_RD_HI,
      S_RD_LO,
      S_RD_EMIT,
      S_STATUS
   } state_type;

   typedef struct packed {
      logic       init;
      logic       load;
      logic [7:0] data;
   } crc_ctl_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] value;
   } crc_stat_type;

endpackage

### rtl/core/mrtu_crc_unit.sv
// Bit-serial CRC-16/Modbus engine, one polynomial step per cycle, eight per byte.
// Depends on mrtu_pkg.
module mrtu_crc_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  mrtu_pkg::crc_ctl_type ctl,
   output mrtu_pkg::crc_stat_type stat
);

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  steps_ff, steps_in;
   logic        busy_ff, busy_in;

   function automatic logic [15:0] crc_shift(input logic [15:0] v);
      logic [15:0] r;
      r = {1'b0, v[15:1]};
      if (v[0]) begin
         r = r ^ mrtu_pkg::CRC_POLY;
      end
      return r;
   endfunction

   always_comb begin
      crc_in   = crc_ff;
      steps_in = steps_ff;
      busy_in  = busy_ff;
      priority if (ctl.init) begin
         crc_in   = mrtu_pkg::CRC_INIT;
         steps_in = 3'd0;
         busy_in  = 1'b0;
      end else if (ctl.load) begin
         crc_in   = crc_shift(crc_ff ^ {8'h00, ctl.data});
         steps_in = 3'd7;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         crc_in   = crc_shift(crc_ff);
         steps_in = steps_ff - 3'd1;
         busy_in  = (steps_ff != 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= mrtu_pkg::CRC_INIT;
         steps_ff <= 3'd0;
         busy_ff  <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         steps_ff <= steps_in;
         busy_ff  <= busy_in;
      end
   end

   assign stat.busy  = busy_ff;
   assign stat.value = crc_ff;

endmodule

### rtl/core/mrtu_reply_ram.sv
// Reply byte store: one write port, one registered read port.
// No dependencies.
module mrtu_reply_ram #(
   parameter int DEPTH  = 69,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data_ff
);

   logic [7:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

### rtl/core/modbus_rtu_master_transaction_unit.sv
// Modbus RTU master transaction unit: request framing, reply capture and checking.
// Depends on mrtu_pkg, mrtu_crc_unit and mrtu_reply_ram.
//
// One beat in at a time, ready only while the sequencer is idle. A write or read
// request runs its six header bytes through the shared bit-serial CRC engine one
// byte after another, then emits eight transmit beats, one per cycle while the
// output register drains. A received byte is stored and, when it is covered by the
// CRC, run through the CRC engine before the next beat is taken; a tick counts
// towards the timeout. A read reply that passes its checks is unloaded word by
// word from the reply store's single read port, then one status beat closes the run.
module modbus_rtu_master_transaction_unit #(
   parameter int MAX_READ_REGS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_register_address,
   input  logic [15:0] req_write_value,
   input  logic [5:0]  req_register_count,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [15:0] rsp_read_word,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int DEPTH   = 5 + 2 * MAX_READ_REGS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LEN_MAX = (DEPTH > 8) ? DEPTH : 8;
   localparam int CNT_W   = $clog2(LEN_MAX + 1);
   localparam int RCNT_W  = $clog2(MAX_READ_REGS + 1);

   // configuration registers
   logic [7:0]  dev_addr_ff;
   logic [15:0] timeout_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= mrtu_pkg::DEVICE_RESET;
         timeout_ff  <= mrtu_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         unique case (mrtu_pkg::reg_index_type'(paddr[2]))
            mrtu_pkg::REG_DEVICE_ADDRESS: dev_addr_ff <= pwdata[7:0];
            mrtu_pkg::REG_TIMEOUT_TICKS:  timeout_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (mrtu_pkg::reg_index_type'(paddr[2]))
         mrtu_pkg::REG_DEVICE_ADDRESS: prdata = {24'h0, dev_addr_ff};
         mrtu_pkg::REG_TIMEOUT_TICKS:  prdata = {16'h0, timeout_ff};
         default:                      prdata = 32'h0;
      endcase
   end

   // sequencer and datapath state
   mrtu_pkg::state_type state_ff, state_in;

   logic [7:0]        req_byte_ff [8];
   logic [7:0]        req_byte_in [8];
   logic [2:0]        idx_ff, idx_in;
   logic [2:0]        req_rd_idx;
   logic [7:0]        req_rd_byte;
   logic [RCNT_W-1:0] word_idx_ff, word_idx_in;
   logic [RCNT_W-1:0] rcnt_ff, rcnt_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              is_write_ff, is_write_in;
   logic              waiting_ff, waiting_in;
   logic [15:0]       wait_ff, wait_in;
   logic [7:0]        addr_byte_ff, addr_byte_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [7:0]        crc_hi_ff, crc_hi_in;
   logic              echo_bad_ff, echo_bad_in;
   logic [7:0]        hi_ff, hi_in;
   mrtu_pkg::status_type status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   mrtu_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_tx_ff, rsp_tx_in;
   logic [15:0]       rsp_word_ff, rsp_word_in;
   mrtu_pkg::status_type rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_ok;

   mrtu_pkg::crc_ctl_type  crc_ctl;
   mrtu_pkg::crc_stat_type crc_stat;

   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   mrtu_pkg::opcode_type op;
   logic              accept;
   logic              op_is_write;
   logic [RCNT_W-1:0] cnt_clamped;
   logic              byte_take;
   logic [CNT_W-1:0]  count_plus1;
   logic              rx_crc_needed;
   logic              rx_complete;
   logic [15:0]       wait_next;
   logic              tick_expire;
   logic              crc_match;
   mrtu_pkg::status_type eval_status;
   logic              last_word;
   logic [ADDR_W-1:0] word_base;

   assign op          = mrtu_pkg::opcode_type'(req_opcode);
   assign req_ready   = (state_ff == mrtu_pkg::S_IDLE);
   assign accept      = req_valid && req_ready;
   assign op_is_write = (op == mrtu_pkg::OP_WRITE);
   assign out_ok      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (req_register_count == 6'd0) begin
         cnt_clamped = RCNT_W'(1);
      end else if ({1'b0, req_register_count} > 7'(MAX_READ_REGS)) begin
         cnt_clamped = RCNT_W'(MAX_READ_REGS);
      end else begin
         cnt_clamped = RCNT_W'(req_register_count);
      end
   end

   assign byte_take     = (count_ff < len_ff) && (count_ff < CNT_W'(DEPTH));
   assign count_plus1   = count_ff + CNT_W'(1);
   assign rx_crc_needed = ({1'b0, count_ff} + (CNT_W + 1)'(2)) < {1'b0, len_ff};
   assign rx_complete   = (count_plus1 == len_ff);
   assign wait_next     = wait_ff + 16'd1;
   assign tick_expire   = (wait_next >= timeout_ff);
   assign crc_match     = (crc_lo_ff == crc_stat.value[7:0]) &&
                          (crc_hi_ff == crc_stat.value[15:8]);
   assign last_word     = ((word_idx_ff + RCNT_W'(1)) == rcnt_ff);
   assign word_base     = ADDR_W'(3) + ADDR_W'({word_idx_ff, 1'b0});
   assign req_rd_byte   = req_byte_ff[req_rd_idx];

   always_comb begin
      priority if (!crc_match) begin
         eval_status = mrtu_pkg::ST_CRC_BAD;
      end else if (addr_byte_ff != dev_addr_ff) begin
         eval_status = mrtu_pkg::ST_WRONG_DEV;
      end else if (is_write_ff && echo_bad_ff) begin
         eval_status = mrtu_pkg::ST_ECHO_BAD;
      end else begin
         eval_status = mrtu_pkg::ST_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mrtu_pkg::S_IDLE: begin
            if (accept) begin
               unique case (op)
                  mrtu_pkg::OP_WRITE, mrtu_pkg::OP_READ: begin
                     if (!waiting_ff) state_in = mrtu_pkg::S_REQ_CRC;
                  end
                  mrtu_pkg::OP_BYTE: begin
                     if (waiting_ff && byte_take) begin
                        priority if (rx_complete) state_in = mrtu_pkg::S_EVAL;
                        else if (rx_crc_needed) state_in = mrtu_pkg::S_RX_CRC;
                     end
                  end
                  mrtu_pkg::OP_TICK: begin
                     if (waiting_ff && tick_expire) state_in = mrtu_pkg::S_STATUS;
                  end
                  default: ;
               endcase
            end
         end
         mrtu_pkg::S_REQ_CRC: state_in = mrtu_pkg::S_REQ_WAIT;
         mrtu_pkg::S_REQ_WAIT: begin
            if (!crc_stat.busy && idx_ff == 3'd5) state_in = mrtu_pkg::S_TX;
         end
         mrtu_pkg::S_TX: begin
            if (out_ok && idx_ff == 3'd7) state_in = mrtu_pkg::S_IDLE;
         end
         mrtu_pkg::S_RX_CRC: begin
            if (!crc_stat.busy) state_in = mrtu_pkg::S_IDLE;
         end
         mrtu_pkg::S_EVAL: begin
            if (eval_status != mrtu_pkg::ST_OK || is_write_ff) begin
               state_in = mrtu_pkg::S_STATUS;
            end else begin
               state_in = mrtu_pkg::S_RD_HI;
            end
         end
         mrtu_pkg::S_RD_HI: state_in = mrtu_pkg::S_RD_LO;
         mrtu_pkg::S_RD_LO: state_in = mrtu_pkg::S_RD_EMIT;
         mrtu_pkg::S_RD_EMIT: begin
            if (out_ok) state_in = last_word ? mrtu_pkg::S_STATUS : mrtu_pkg::S_RD_HI;
         end
         mrtu_pkg::S_STATUS: begin
            if (out_ok) state_in = mrtu_pkg::S_IDLE;
         end
         default: state_in = mrtu_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_byte_in   = req_byte_ff;
      idx_in        = idx_ff;
      word_idx_in   = word_idx_ff;
      rcnt_in       = rcnt_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      is_write_in   = is_write_ff;
      waiting_in    = waiting_ff;
      wait_in       = wait_ff;
      addr_byte_in  = addr_byte_ff;
      crc_lo_in     = crc_lo_ff;
      crc_hi_in     = crc_hi_ff;
      echo_bad_in   = echo_bad_ff;
      hi_in         = hi_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tx_in     = rsp_tx_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      crc_ctl       = '0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = word_base;
      req_rd_idx    = idx_ff;

      unique case (state_ff)
         mrtu_pkg::S_IDLE: begin
            req_rd_idx = count_ff[2:0];
            if (accept) begin
               unique case (op)
                  mrtu_pkg::OP_WRITE, mrtu_pkg::OP_READ: begin
                     if (!waiting_ff) begin
                        req_byte_in[0] = dev_addr_ff;
                        req_byte_in[1] = op_is_write ? mrtu_pkg::FUNC_WRITE
                                                     : mrtu_pkg::FUNC_READ;
                        req_byte_in[2] = req_register_address[15:8];
                        req_byte_in[3] = req_register_address[7:0];
                        req_byte_in[4] = op_is_write ? req_write_value[15:8] : 8'h00;
                        req_byte_in[5] = op_is_write ? req_write_value[7:0]
                                                     : 8'(cnt_clamped);
                        is_write_in = op_is_write;
                        rcnt_in     = cnt_clamped;
                        len_in      = op_is_write ? CNT_W'(8)
                                    : CNT_W'(5) + CNT_W'({cnt_clamped, 1'b0});
                        idx_in      = 3'd0;
                        echo_bad_in = 1'b0;
                        crc_ctl.init = 1'b1;
                     end
                  end
                  mrtu_pkg::OP_BYTE: begin
                     if (waiting_ff && byte_take) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_plus1;
                        if (count_ff == '0) addr_byte_in = req_rx_byte;
                        if (is_write_ff && req_rx_byte != req_rd_byte) echo_bad_in = 1'b1;
                        if (rx_crc_needed) begin
                           crc_ctl.load = 1'b1;
                           crc_ctl.data = req_rx_byte;
                        end
                        if (count_plus1 + CNT_W'(1) == len_ff) crc_lo_in = req_rx_byte;
                        if (rx_complete) crc_hi_in = req_rx_byte;
                     end
                  end
                  mrtu_pkg::OP_TICK: begin
                     if (waiting_ff) begin
                        wait_in = wait_next;
                        if (tick_expire) begin
                           status_in = (count_ff == '0) ? mrtu_pkg::ST_NO_REPLY
                                                        : mrtu_pkg::ST_SHORT_REPLY;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         mrtu_pkg::S_REQ_CRC: begin
            crc_ctl.load = 1'b1;
            crc_ctl.data = req_rd_byte;
         end
         mrtu_pkg::S_REQ_WAIT: begin
            req_rd_idx = idx_ff + 3'd1;
            if (!crc_stat.busy) begin
               if (idx_ff == 3'd5) begin
                  req_byte_in[6] = crc_stat.value[7:0];
                  req_byte_in[7] = crc_stat.value[15:8];
                  idx_in = 3'd0;
               end else begin
                  crc_ctl.load = 1'b1;
                  crc_ctl.data = req_rd_byte;
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         mrtu_pkg::S_TX: begin
            if (out_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = mrtu_pkg::KIND_TX;
               rsp_tx_in     = req_rd_byte;
               rsp_word_in   = 16'h0;
               rsp_status_in = mrtu_pkg::ST_OK;
               rsp_last_in   = (idx_ff == 3'd7);
               idx_in        = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  waiting_in   = 1'b1;
                  count_in     = '0;
                  wait_in      = 16'h0;
                  crc_ctl.init = 1'b1;
               end
            end
         end
         mrtu_pkg::S_RX_CRC: ;
         mrtu_pkg::S_EVAL: begin
            status_in   = eval_status;
            word_idx_in = '0;
         end
         mrtu_pkg::S_RD_HI: begin
            mem_rd_en = 1'b1;
         end
         mrtu_pkg::S_RD_LO: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = word_base + ADDR_W'(1);
            hi_in       = mem_rd_data;
         end
         mrtu_pkg::S_RD_EMIT: begin
            if (out_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = mrtu_pkg::KIND_READ;
               rsp_tx_in     = 8'h0;
               rsp_word_in   = {hi_ff, mem_rd_data};
               rsp_status_in = mrtu_pkg::ST_OK;
               rsp_last_in   = 1'b0;
               word_idx_in   = word_idx_ff + RCNT_W'(1);
            end
         end
         mrtu_pkg::S_STATUS: begin
            if (out_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = mrtu_pkg::KIND_STATUS;
               rsp_tx_in     = 8'h0;
               rsp_word_in   = 16'h0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               waiting_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrtu_pkg::S_IDLE;
         waiting_ff   <= 1'b0;
         is_write_ff  <= 1'b0;
         count_ff     <= '0;
         len_ff       <= '0;
         wait_ff      <= 16'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         is_write_ff  <= is_write_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_byte_ff   <= req_byte_in;
      idx_ff        <= idx_in;
      word_idx_ff   <= word_idx_in;
      rcnt_ff       <= rcnt_in;
      addr_byte_ff  <= addr_byte_in;
      crc_lo_ff     <= crc_lo_in;
      crc_hi_ff     <= crc_hi_in;
      echo_bad_ff   <= echo_bad_in;
      hi_ff         <= hi_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tx_ff     <= rsp_tx_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   mrtu_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .stat  (crc_stat)
   );

   mrtu_reply_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_reply_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (count_ff[ADDR_W-1:0]),
      .wr_data    (req_rx_byte),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_tx_byte     = rsp_tx_ff;
   assign rsp_read_word   = rsp_word_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef ASSERT_OFF
   a_idle_crc_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !crc_stat.busy)
      else $error("CRC engine busy while accepting beats");

   a_eval_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrtu_pkg::S_EVAL) |-> waiting_ff)
      else $error("reply evaluated with no transaction open");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrtu_pkg::S_IDLE && waiting_ff) |-> (count_ff < len_ff))
      else $error("reply count reached expected length while idle");

   a_word_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff != mrtu_pkg::KIND_READ))
      else $error("read data beat flagged as last");
`endif

endmodule

### test/testbench.sv
// Testbench for the Modbus RTU master transaction unit: request framing, reply checks, timeouts.
// Depends on mrtu_pkg and the unit itself; self-contained predictor, random stimulus and idling.
`timescale 1ns / 1ps

module testbench;
   import mrtu_pkg::*;

   localparam int REG_LIMIT    = 32;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int SETTLE_TICKS = 20;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx;
      logic [15:0] word;
      logic [2:0]  st;
      logic        last;
   } rsp_beat_t;

   typedef enum int {
      FAULT_NONE,
      FAULT_CRC,
      FAULT_DEVICE,
      FAULT_ECHO,
      FAULT_SHORT,
      FAULT_SILENT
   } reply_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_TICK;
   logic [15:0] req_register_address = '0;
   logic [15:0] req_write_value = '0;
   logic [5:0]  req_register_count = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_tx_byte;
   logic [15:0] rsp_read_word;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   logic [7:0]  cfg_device;
   logic [15:0] cfg_timeout;
   bit          awaiting;
   bit          pending_write;
   logic [7:0]  frame [8];
   logic [7:0]  reply [5 + 2 * REG_LIMIT];
   int          rx_count;
   int          want_len;
   logic [15:0] rx_crc;
   logic [15:0] tick_count;
   bit          item_counted;

   rsp_beat_t   expected_rsp [$];
   int          fail_count;
   int          beats_checked;
   int          counted_items;
   int          transactions;
   int          cycle_count;

   bit          src_quiet;
   bit          sink_quiet;
   int          hold_pending;
   int          hold_left;
   int          stall_left;

   modbus_rtu_master_transaction_unit #(.MAX_READ_REGS(REG_LIMIT)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_register_address(req_register_address),
      .req_write_value(req_write_value),
      .req_register_count(req_register_count),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_read_word(rsp_read_word),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  expected_rsp.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   task automatic push_beat(input logic [1:0] kind, input logic [7:0] tx,
                            input logic [15:0] word, input logic [2:0] st, input logic last);
      expected_rsp.push_back({kind, tx, word, st, last});
   endtask

   task automatic close_run(input logic [2:0] st);
      push_beat(KIND_STATUS, 8'h00, 16'h0000, st, 1'b1);
      awaiting = 0;
   endtask

   task automatic judge_reply();
      bit same;
      if (reply[want_len - 2] != rx_crc[7:0] || reply[want_len - 1] != rx_crc[15:8]) begin
         close_run(ST_CRC_BAD);
      end else if (reply[0] != cfg_device) begin
         close_run(ST_WRONG_DEV);
      end else if (pending_write) begin
         same = 1;
         for (int i = 0; i < 8; i++)
            if (reply[i] != frame[i]) same = 0;
         close_run(same ? ST_OK : ST_ECHO_BAD);
      end else begin
         for (int i = 0; i < (want_len - 5) / 2; i++)
            push_beat(KIND_READ, 8'h00, {reply[3 + 2 * i], reply[4 + 2 * i]}, ST_OK, 1'b0);
         close_run(ST_OK);
      end
   endtask

   task automatic predict(input logic [1:0] op, input logic [15:0] addr,
                          input logic [15:0] val, input logic [5:0] cnt, input logic [7:0] rxb);
      int n;
      logic [15:0] c;
      item_counted = 1;
      case (op)
         OP_WRITE, OP_READ: begin
            if (awaiting) begin
               item_counted = 0;
            end else begin
               if (op == OP_WRITE) begin
                  pending_write = 1;
                  want_len = 8;
                  frame[1] = FUNC_WRITE;
                  frame[4] = val[15:8];
                  frame[5] = val[7:0];
               end else begin
                  n = (cnt == 0) ? 1 : (cnt > REG_LIMIT) ? REG_LIMIT : int'(cnt);
                  pending_write = 0;
                  want_len = 5 + 2 * n;
                  frame[1] = FUNC_READ;
                  frame[4] = 8'h00;
                  frame[5] = n[7:0];
               end
               frame[0] = cfg_device;
               frame[2] = addr[15:8];
               frame[3] = addr[7:0];
               c = 16'hFFFF;
               for (int i = 0; i < 6; i++)
                  c = crc_step(c, frame[i]);
               frame[6] = c[7:0];
               frame[7] = c[15:8];
               for (int i = 0; i < 8; i++)
                  push_beat(KIND_TX, frame[i], 16'h0000, ST_OK, i == 7);
               awaiting = 1;
               rx_count = 0;
               rx_crc = 16'hFFFF;
               tick_count = 0;
               transactions++;
            end
         end
         OP_BYTE: begin
            if (!awaiting) begin
               item_counted = 0;
            end else begin
               if (rx_count < want_len) begin
                  reply[rx_count] = rxb;
                  if (rx_count + 2 < want_len) rx_crc = crc_step(rx_crc, rxb);
                  rx_count++;
               end
               if (rx_count >= want_len) judge_reply();
            end
         end
         default: begin
            if (!awaiting) begin
               item_counted = 0;
            end else begin
               tick_count = tick_count + 16'd1;
               if (tick_count >= cfg_timeout)
                  close_run(rx_count == 0 ? ST_NO_REPLY : ST_SHORT_REPLY);
            end
         end
      endcase
      if (item_counted) counted_items++;
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_pending > 0) begin
            hold_left = hold_pending;
            hold_pending = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!sink_quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_beat_t got;
      rsp_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_result_kind, rsp_tx_byte, rsp_read_word, rsp_status, rsp_last};
         if (expected_rsp.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected beat, expected none, actual kind=%0d tx=%h word=%h st=%0d last=%0b",
                     $time, got.kind, got.tx, got.word, got.st, got.last);
         end else begin
            want = expected_rsp.pop_front();
            beats_checked++;
            if (got.kind !== want.kind || got.tx !== want.tx || got.word !== want.word ||
                got.st !== want.st || got.last !== want.last) begin
               fail_count++;
               $display("%0t: mismatch, expected kind=%0d tx=%h word=%h st=%0d last=%0b",
                        $time, want.kind, want.tx, want.word, want.st, want.last);
               $display("%0t:           actual   kind=%0d tx=%h word=%h st=%0d last=%0b",
                        $time, got.kind, got.tx, got.word, got.st, got.last);
            end
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_beat(input logic [1:0] op, input logic [15:0] addr,
                            input logic [15:0] val, input logic [5:0] cnt, input logic [7:0] rxb);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_register_address <= addr;
      req_write_value <= val;
      req_register_count <= cnt;
      req_rx_byte <= rxb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict(op, addr, val, cnt, rxb);
      if (!src_quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_beat(OP_BYTE, $urandom, $urandom, $urandom, b);
   endtask

   task automatic send_tick();
      send_beat(OP_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      wait_drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DEVICE_ADDRESS) cfg_device = value[7:0];
      else cfg_timeout = value[15:0];
   endtask

   task automatic csr_read_check(input reg_index_type idx, input logic [31:0] want);
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         fail_count++;
         $display("%0t: register %0d read, expected %h actual %h", $time, idx, want, prdata);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return $urandom;
      endcase
   endfunction

   // request, then a reply shaped by the fault; noise_odds 0 means a clean line
   task automatic run_transaction(input bit wr, input logic [15:0] addr, input logic [15:0] val,
                                  input logic [5:0] cnt, input reply_fault_type fault,
                                  input int noise_odds, input int move_device = -1);
      logic [7:0] rep [$];
      logic [15:0] c;
      int len;
      int stop;
      int k;
      send_beat(wr ? OP_WRITE : OP_READ, addr, val, cnt, $urandom);
      if (move_device >= 0) csr_write(REG_DEVICE_ADDRESS, move_device);
      len = want_len;
      if (fault == FAULT_DEVICE) rep.push_back(cfg_device ^ 8'($urandom_range(1, 255)));
      else rep.push_back(cfg_device);
      if (wr) begin
         for (k = 1; k < 6; k++) rep.push_back(frame[k]);
         if (fault == FAULT_ECHO) begin
            k = $urandom_range(1, 5);
            rep[k] = rep[k] ^ (8'h01 << $urandom_range(0, 7));
         end
      end else begin
         rep.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : FUNC_READ);
         rep.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'(len - 5));
         for (k = 0; k < len - 5; k++) rep.push_back($urandom);
      end
      c = 16'hFFFF;
      foreach (rep[i]) c = crc_step(c, rep[i]);
      rep.push_back(c[7:0]);
      rep.push_back(c[15:8]);
      if (fault == FAULT_CRC) begin
         k = len - 1 - $urandom_range(0, 1);
         rep[k] = rep[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      stop = (fault == FAULT_SHORT) ? $urandom_range(1, len - 1) :
             (fault == FAULT_SILENT) ? 0 : len;
      for (k = 0; k < stop; k++) begin
         if (noise_odds > 0 && $urandom_range(1, noise_odds) == 1 && awaiting) begin
            if ($urandom_range(0, 1) == 0) send_tick();
            else send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
         end
         send_byte(rep[k]);
      end
      if (fault == FAULT_SHORT || fault == FAULT_SILENT)
         while (awaiting) send_tick();
   endtask

   // ---------------- tests ----------------

   task automatic test_register_defaults();
      csr_read_check(REG_DEVICE_ADDRESS, 32'(DEVICE_RESET));
      csr_read_check(REG_TIMEOUT_TICKS, 32'(TIMEOUT_RESET));
      run_transaction(1, 16'hFFFF, 16'h0000, 6'd0, FAULT_NONE, 0);
   endtask

   task automatic test_idle_noise();
      send_byte(8'hFF);
      send_tick();
   endtask

   task automatic test_read_clamp_low();
      run_transaction(0, 16'h0000, 16'hFFFF, 6'd0, FAULT_NONE, 0);
   endtask

   task automatic test_timeouts();
      csr_write(REG_TIMEOUT_TICKS, 32'd0);
      csr_read_check(REG_TIMEOUT_TICKS, 32'd0);
      run_transaction(0, 16'h1234, 16'h0000, 6'd1, FAULT_SILENT, 0);
      run_transaction(1, 16'h00FF, 16'hFF00, 6'd63, FAULT_SHORT, 0);
   endtask

   task automatic test_reply_faults();
      csr_write(REG_DEVICE_ADDRESS, 32'hA5);
      csr_write(REG_TIMEOUT_TICKS, 32'hFFFF);
      csr_read_check(REG_DEVICE_ADDRESS, 32'hA5);
      csr_read_check(REG_TIMEOUT_TICKS, 32'hFFFF);
      run_transaction(1, 16'h0102, 16'h0304, 6'd5, FAULT_CRC, 0);
      run_transaction(0, 16'h0010, 16'h0000, 6'd2, FAULT_DEVICE, 0);
      run_transaction(1, 16'hBEEF, 16'hCAFE, 6'd1, FAULT_ECHO, 0);
      // every reply byte preceded by a tick or an ignored request
      run_transaction(0, 16'h7FFF, 16'h8000, 6'd2, FAULT_NONE, 1);
   endtask

   task automatic test_address_change();
      csr_write(REG_DEVICE_ADDRESS, 32'h3C);
      run_transaction(0, 16'h4000, 16'h0000, 6'd1, FAULT_NONE, 0, 32'hC3);
      run_transaction(1, 16'h4001, 16'h5555, 6'd0, FAULT_NONE, 0, 32'h00);
   endtask

   task automatic test_backpressure();
      wait_drain();
      src_quiet = 1;
      hold_pending = 300;
      run_transaction(1, 16'hA0A0, 16'h0A0A, 6'd0, FAULT_NONE, 0);
      run_transaction(0, 16'h0A0A, 16'h0000, 6'd3, FAULT_NONE, 0);
      run_transaction(1, 16'h5A5A, 16'hA5A5, 6'd0, FAULT_NONE, 0);
      wait_drain();
      src_quiet = 0;
   endtask

   task automatic test_large_read();
      run_transaction(0, 16'hFFFE, 16'h0000, 6'd63, FAULT_NONE, 0);
   endtask

   task automatic test_random_phase(input int goal, input logic [7:0] device,
                                    input logic [15:0] timeout, input bit quiet);
      int start;
      int r;
      logic [5:0] cnt;
      reply_fault_type fault;
      csr_write(REG_DEVICE_ADDRESS, device);
      csr_write(REG_TIMEOUT_TICKS, timeout);
      src_quiet = quiet;
      sink_quiet = quiet;
      start = counted_items;
      while (counted_items - start < goal) begin
         if ($urandom_range(0, 11) == 0) begin
            if (awaiting) send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
            else if ($urandom_range(0, 1) == 0) send_tick();
            else send_byte($urandom);
         end else if (awaiting) begin
            send_byte($urandom);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) cnt = $urandom_range(33, 63);
            else if (r < 9) cnt = 0;
            else if (r < 14) cnt = $urandom_range(5, 32);
            else cnt = $urandom_range(1, 4);
            r = $urandom_range(0, 99);
            fault = (r < 50) ? FAULT_NONE : reply_fault_type'($urandom_range(1, 5));
            if (cfg_timeout > 64 && (fault == FAULT_SHORT || fault == FAULT_SILENT))
               fault = FAULT_NONE;
            run_transaction($urandom_range(0, 1), pick16(), pick16(), cnt, fault, 16);
         end
      end
   endtask

   initial begin
      cfg_device = DEVICE_RESET;
      cfg_timeout = TIMEOUT_RESET;
      awaiting = 0;
      pending_write = 0;
      rx_count = 0;
      want_len = 0;
      rx_crc = 16'hFFFF;
      tick_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_idle_noise();
      test_read_clamp_low();
      test_timeouts();
      test_reply_faults();
      test_address_change();
      test_backpressure();
      test_large_read();
      test_random_phase(70, $urandom, $urandom_range(2, 16), 0);
      test_random_phase(50, 8'h00, 16'h0000, 0);
      test_random_phase(50, 8'hFF, 16'hFFFF, 0);
      test_random_phase(70, $urandom, $urandom_range(1, 40), 1);

      wait_drain();
      $display("%0d transactions over %0d accepted items, %0d result beats checked",
               transactions, counted_items, beats_checked);
      $display("faults, timeouts, clamped counts, busy and idle noise, device and timeout extremes");
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/mrtu_pkg.sv
rtl/core/mrtu_crc_unit.sv
rtl/core/mrtu_reply_ram.sv
rtl/core/modbus_rtu_master_transaction_unit.sv
test/testbench.sv
